// ===== design/puws_pkg.sv =====
// Package for the priority unit work scheduler.
// It holds the command codes, the field widths and the beat that runs down the chain of slot cells.
// It depends on nothing else.
package puws_pkg;

    localparam int PRIO_W = 16;
    localparam int WORK_W = 16;
    localparam int COST_W = 48;
    localparam int PROD_W = PRIO_W + WORK_W;

    localparam logic [1:0] CMD_ARRIVE = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    typedef struct packed {
        logic              active;
        logic [1:0]        cmd;
        logic [PRIO_W-1:0] prio;
        logic [WORK_W-1:0] work;
        logic              found;
        logic [PRIO_W-1:0] best_prio;
        logic [WORK_W-1:0] best_rem;
        logic [COST_W-1:0] sum;
    } puws_token_t;

    typedef struct packed {
        logic              accepted;
        logic              table_full;
        logic              served_valid;
        logic [PRIO_W-1:0] served_priority;
        logic              served_done;
        logic [COST_W-1:0] residual_cost;
        logic              cost_valid;
    } puws_result_t;

endpackage

// ===== design/puws_cell.sv =====
// One slot of the scheduler table and one stage of the command chain.
// It depends on puws_pkg and is instantiated once per slot by the top level.
module puws_cell
    import puws_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int INDEX = 0
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  puws_token_t       tok_in,
    input  logic [IDX_W-1:0]  idx_in,
    input  logic              commit_en,
    input  logic [IDX_W-1:0]  commit_idx,
    output puws_token_t       tok_out,
    output logic [IDX_W-1:0]  idx_out
);

    logic              valid_reg;
    logic              valid_next;
    logic [PRIO_W-1:0] prio_reg;
    logic [PRIO_W-1:0] prio_next;
    logic [WORK_W-1:0] rem_reg;
    logic [WORK_W-1:0] rem_next;
    puws_token_t       tok_reg;
    puws_token_t       tok_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [PROD_W-1:0] product;
    logic [COST_W:0]   total;
    logic              selected;

    assign product  = PROD_W'(prio_reg) * PROD_W'(rem_reg);
    assign total    = {1'b0, tok_in.sum} + (COST_W + 1)'(product);
    assign selected = commit_en && (commit_idx == IDX_W'(INDEX));

    always_comb
    begin
        valid_next = valid_reg;
        prio_next  = prio_reg;
        rem_next   = rem_reg;
        tok_next   = tok_in;
        idx_next   = idx_in;
        if (tok_in.active)
        begin
            case (tok_in.cmd)
                CMD_ARRIVE:
                begin
                    if (!valid_reg && !tok_in.found)
                    begin
                        valid_next     = 1'b1;
                        prio_next      = tok_in.prio;
                        rem_next       = tok_in.work;
                        tok_next.found = 1'b1;
                    end
                end
                CMD_TICK:
                begin
                    if (valid_reg && (!tok_in.found || prio_reg > tok_in.best_prio))
                    begin
                        tok_next.found     = 1'b1;
                        tok_next.best_prio = prio_reg;
                        tok_next.best_rem  = rem_reg;
                        idx_next           = IDX_W'(INDEX);
                    end
                end
                CMD_FINISH:
                begin
                    if (valid_reg)
                    begin
                        tok_next.sum = total[COST_W] ? {COST_W{1'b1}} : total[COST_W-1:0];
                    end
                    valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        if (selected)
        begin
            if (rem_reg > WORK_W'(1))
            begin
                rem_next = rem_reg - WORK_W'(1);
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prio_reg <= prio_next;
        rem_reg  <= rem_next;
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

// ===== design/priority_unit_work_scheduler.sv =====
// Top level of the priority unit work scheduler: command intake, the chain of slot cells,
// and the result register. It depends on puws_pkg and puws_cell.
//
//  Channel  Direction  Signals                                 Contents
//  s_axis   in         s_tvalid s_tready s_tdata s_tuser       command, job priority, job work
//  m_axis   out        m_tvalid m_tready m_tdata m_tuser       one result beat per command
//
// A command runs down the chain one cell per cycle. It passes the intake register,
// the register of every cell and the result register before its result beat appears
// from the output register.
// The next command is taken once the result sits in the output register.
// Reset empties every slot at once; slot contents are loaded by arrivals.
// A stall on the output holds the result and blocks new commands only while a
// second result would have nowhere to go.
module priority_unit_work_scheduler
    import puws_pkg::*;
#(
    parameter int NUM_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // job_priority [15:0], job_work [31:16]
    input  logic [1:0]  s_tuser,   // command [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // accepted, table_full, served_priority [17:2],
                                   // served_done [18], residual_cost [66:19], zero fill
    output logic [1:0]  m_tuser    // served_valid [0], cost_valid [1]
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_PEND} state_t;

    state_t       state_reg;
    state_t       state_next;
    puws_token_t  tok_in_reg;
    puws_token_t  tok_in_next;
    puws_result_t res_reg;
    puws_result_t res_next;
    puws_result_t out_reg;
    puws_result_t out_next;
    logic         out_valid_reg;
    logic         out_valid_next;

    puws_token_t      tok [0:NUM_SLOTS];
    logic [IDX_W-1:0] idx [0:NUM_SLOTS];
    puws_token_t      last_tok;
    logic             commit_en;

    assign tok[0]   = tok_in_reg;
    assign idx[0]   = '0;
    assign last_tok = tok[NUM_SLOTS];

    genvar k;
    generate
        for (k = 0; k < NUM_SLOTS; k++)
        begin : g_cell
            puws_cell #(
                .IDX_W (IDX_W),
                .INDEX (k)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .tok_in     (tok[k]),
                .idx_in     (idx[k]),
                .commit_en  (commit_en),
                .commit_idx (idx[NUM_SLOTS]),
                .tok_out    (tok[k+1]),
                .idx_out    (idx[k+1])
            );
        end
    endgenerate

    assign s_tready  = (state_reg == ST_IDLE);
    assign commit_en = (state_reg == ST_SCAN) && last_tok.active &&
                       (last_tok.cmd == CMD_TICK) && last_tok.found;

    always_comb
    begin
        state_next     = state_reg;
        tok_in_next    = tok_in_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        tok_in_next.active = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    tok_in_next.active    = 1'b1;
                    tok_in_next.cmd       = s_tuser;
                    tok_in_next.prio      = s_tdata[15:0];
                    tok_in_next.work      = s_tdata[31:16];
                    tok_in_next.found     = 1'b0;
                    tok_in_next.best_prio = '0;
                    tok_in_next.best_rem  = '0;
                    tok_in_next.sum       = '0;
                    state_next            = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_tok.active)
                begin
                    res_next = '0;
                    case (last_tok.cmd)
                        CMD_ARRIVE:
                        begin
                            res_next.accepted   = last_tok.found;
                            res_next.table_full = !last_tok.found;
                        end
                        CMD_TICK:
                        begin
                            res_next.served_valid    = last_tok.found;
                            res_next.served_priority = last_tok.best_prio;
                            res_next.served_done     = last_tok.found &&
                                                       (last_tok.best_rem <= WORK_W'(1));
                        end
                        CMD_FINISH:
                        begin
                            res_next.residual_cost = last_tok.sum;
                            res_next.cost_valid    = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = ST_PEND;
                end
            end
            ST_PEND:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tok_in_reg    <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tok_in_reg    <= tok_in_next;
            res_reg       <= res_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid       = out_valid_reg;
    assign m_tdata[0]     = out_reg.accepted;
    assign m_tdata[1]     = out_reg.table_full;
    assign m_tdata[17:2]  = out_reg.served_priority;
    assign m_tdata[18]    = out_reg.served_done;
    assign m_tdata[66:19] = out_reg.residual_cost;
    assign m_tdata[71:67] = '0;
    assign m_tuser[0]     = out_reg.served_valid;
    assign m_tuser[1]     = out_reg.cost_valid;

endmodule

// ===== design/puws_checker.sv =====
// Port-level checks for the priority unit work scheduler, bound to the top level.
// It depends only on the top level's ports.
module puws_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("Result beat changed while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("A second command was taken while one was in the chain.");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $onehot0({m_tdata[0] | m_tdata[1], m_tuser[0], m_tuser[1]}))
        else $error("Result beat mixes fields of different commands.");

    a_arrive_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("An arrival was both stored and dropped.");

    a_served_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> !m_tdata[18] && (m_tdata[17:2] == 16'd0))
        else $error("Service fields set without a served job.");

endmodule

bind priority_unit_work_scheduler puws_checker u_puws_checker (.*);

// ===== sim/sched_checker.sv =====
`timescale 1ns / 1ps
// Checker for the priority unit work scheduler: it watches both stream channels, keeps its
// own copy of the job table, works out each result beat and compares it with the block's.
// It depends on puws_pkg.
module sched_checker
    import puws_pkg::*;
#(
    parameter int NUM_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // job_priority [15:0], job_work [31:16]
    input  logic [1:0]  s_tuser,   // command [1:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // accepted, table_full, served_priority [17:2],
                                   // served_done [18], residual_cost [66:19], zero fill
    input  logic [1:0]  m_tuser,   // served_valid [0], cost_valid [1]
    output int          mismatches,
    output int          outstanding,
    output int          checked,
    output int          full_drops,
    output int          empty_ticks
);

    localparam logic [63:0] COST_SAT = 64'h0000_FFFF_FFFF_FFFF;

    logic [PRIO_W-1:0] job_prio [NUM_SLOTS];
    logic [WORK_W-1:0] job_left [NUM_SLOTS];
    bit                job_live [NUM_SLOTS];
    puws_result_t      due_results [$];

    int err_count;
    int due_count;
    int seen_count;
    int drop_count;
    int idle_tick_count;

    assign mismatches  = err_count;
    assign outstanding = due_count;
    assign checked     = seen_count;
    assign full_drops  = drop_count;
    assign empty_ticks = idle_tick_count;

    function automatic puws_result_t advance_table(input logic [1:0] cmd,
                                                   input logic [PRIO_W-1:0] prio,
                                                   input logic [WORK_W-1:0] work);
        puws_result_t r;
        int best;
        logic [63:0] sum;
        r = '0;
        best = -1;
        sum = '0;
        case (cmd)
            CMD_ARRIVE:
            begin
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    if (!job_live[k] && !r.accepted)
                    begin
                        job_live[k] = 1'b1;
                        job_prio[k] = prio;
                        job_left[k] = work;
                        r.accepted = 1'b1;
                    end
                end
                r.table_full = !r.accepted;
            end
            CMD_TICK:
            begin
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    if (job_live[k] && (best < 0 || job_prio[k] > job_prio[best]))
                        best = k;
                end
                if (best >= 0)
                begin
                    r.served_valid = 1'b1;
                    r.served_priority = job_prio[best];
                    if (job_left[best] > 1)
                        job_left[best] = job_left[best] - 1'b1;
                    else
                    begin
                        job_live[best] = 1'b0;
                        job_left[best] = '0;
                        r.served_done = 1'b1;
                    end
                end
            end
            CMD_FINISH:
            begin
                for (int k = 0; k < NUM_SLOTS; k++)
                begin
                    if (job_live[k])
                    begin
                        sum = sum + 64'(job_prio[k]) * 64'(job_left[k]);
                        if (sum > COST_SAT)
                            sum = COST_SAT;
                    end
                    job_live[k] = 1'b0;
                end
                r.residual_cost = sum[COST_W-1:0];
                r.cost_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        puws_result_t want;
        puws_result_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
                job_live[k] = 1'b0;
            due_results.delete();
            err_count = 0;
            due_count = 0;
            seen_count = 0;
            drop_count = 0;
            idle_tick_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.accepted        = m_tdata[0];
                got.table_full      = m_tdata[1];
                got.served_priority = m_tdata[17:2];
                got.served_done     = m_tdata[18];
                got.residual_cost   = m_tdata[66:19];
                got.served_valid    = m_tuser[0];
                got.cost_valid      = m_tuser[1];
                seen_count++;
                if (due_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("%0t: result beat with nothing expected", $realtime);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.accepted !== want.accepted
                        || got.table_full !== want.table_full
                        || got.served_valid !== want.served_valid
                        || got.served_priority !== want.served_priority
                        || got.served_done !== want.served_done
                        || got.residual_cost !== want.residual_cost
                        || got.cost_valid !== want.cost_valid)
                    begin
                        err_count++;
                        if (err_count <= 10)
                        begin
                            $display("%0t: expected acc=%b full=%b sv=%b prio=%h done=%b cost=%h cv=%b",
                                     $realtime, want.accepted, want.table_full, want.served_valid,
                                     want.served_priority, want.served_done, want.residual_cost,
                                     want.cost_valid);
                            $display("%0t: got      acc=%b full=%b sv=%b prio=%h done=%b cost=%h cv=%b",
                                     $realtime, got.accepted, got.table_full, got.served_valid,
                                     got.served_priority, got.served_done, got.residual_cost,
                                     got.cost_valid);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = advance_table(s_tuser, s_tdata[15:0], s_tdata[31:16]);
                if (want.table_full)
                    drop_count++;
                if (s_tuser == CMD_TICK && !want.served_valid)
                    idle_tick_count++;
                due_results = {due_results, want};
            end
            due_count = due_results.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the scheduler testbench: clock, reset, command beats with random gaps, a result
// sink with random stalls, and the verdict. It depends on puws_pkg, the block and sched_checker.
module tb_top;
    import puws_pkg::*;

    localparam int NUM_SLOTS = 64;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_GOAL = 1150;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AT_BEAT = 300;
    localparam int LIMIT_CYCLES = 1_200_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [1:0]  m_tuser;

    int mismatches;
    int outstanding;
    int checked;
    int full_drops;
    int empty_ticks;
    int sent;
    int beats_taken;
    bit src_calm;
    bit sink_calm;

    priority_unit_work_scheduler #(.NUM_SLOTS(NUM_SLOTS)) dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    sched_checker #(.NUM_SLOTS(NUM_SLOTS)) checker_i
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .mismatches(mismatches),
        .outstanding(outstanding),
        .checked(checked),
        .full_drops(full_drops),
        .empty_ticks(empty_ticks)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 10);
        $display("Timeout with %0d results still due.", outstanding);
        $display("tb_top failed");
        $finish;
    end

    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 20);
        return $urandom_range(30, 90);
    endfunction

    function automatic logic [15:0] pick_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 16'($urandom_range(0, 7));
        if (r < 50)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] pick_work();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'($urandom_range(0, 3));
        if (r < 60)
            return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] prio,
                            input logic [15:0] work);
        int gap;
        gap = idle_len(src_calm);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {work, prio};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent++;
    endtask

    task automatic arrive_job();
        send_cmd(CMD_ARRIVE, pick_prio(), pick_work());
    endtask

    task automatic send_bare(input logic [1:0] cmd);
        send_cmd(cmd, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
    endtask

    task automatic mixed_run();
        int n;
        int r;
        n = $urandom_range(3, 20);
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                arrive_job();
            else if (r < 95)
                send_bare(CMD_TICK);
            else
                send_bare(CMD_UNUSED);
        end
        if ($urandom_range(0, 9) != 0)
            send_bare(CMD_FINISH);
    endtask

    task automatic fill_run();
        int n;
        n = NUM_SLOTS + $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_bare(CMD_TICK);
            arrive_job();
        end
        repeat ($urandom_range(1, 6)) send_bare(CMD_TICK);
        repeat (2) arrive_job();
        send_bare(CMD_FINISH);
    endtask

    task automatic drain_run();
        repeat ($urandom_range(1, 5)) send_cmd(CMD_ARRIVE, pick_prio(),
                                               16'($urandom_range(0, 3)));
        repeat ($urandom_range(5, 25)) send_bare(CMD_TICK);
        if ($urandom_range(0, 1) != 0)
            send_bare(CMD_FINISH);
    endtask

    task automatic noise_run();
        repeat ($urandom_range(5, 15)) send_bare(2'($urandom_range(0, 3)));
    endtask

    initial
    begin : sink
        int stall;
        m_tready = 1'b0;
        beats_taken = 0;
        sink_calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (beats_taken % 64 == 0)
                sink_calm = ($urandom_range(0, 3) == 0);
            stall = (beats_taken == HOLD_AT_BEAT) ? HOLD_CYCLES : idle_len(sink_calm);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            beats_taken++;
        end
    end

    initial
    begin : source
        int kind;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        sent = 0;
        src_calm = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_cmd(CMD_TICK, 16'h0000, 16'h0000);
        send_cmd(CMD_FINISH, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_ARRIVE, 16'h0000, 16'h0000);
        send_cmd(CMD_ARRIVE, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_ARRIVE, 16'hFFFF, 16'h0001);
        send_cmd(CMD_ARRIVE, 16'h1234, 16'h0002);
        send_cmd(CMD_UNUSED, 16'hA5A5, 16'h5A5A);
        send_cmd(CMD_TICK, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000);
        send_cmd(CMD_FINISH, 16'h0000, 16'h0000);
        send_cmd(CMD_ARRIVE, 16'h0000, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000);
        send_cmd(CMD_ARRIVE, 16'h0005, 16'h0000);
        send_cmd(CMD_ARRIVE, 16'h0007, 16'h0003);
        send_cmd(CMD_ARRIVE, 16'h0007, 16'h0001);
        send_cmd(CMD_FINISH, 16'h0000, 16'h0000);
        send_cmd(CMD_ARRIVE, 16'h0003, 16'h0001);
        send_cmd(CMD_ARRIVE, 16'h0003, 16'h0002);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000);
        wait_drained();

        while (sent < ITEM_GOAL)
        begin
            src_calm = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 55)
                mixed_run();
            else if (kind < 62)
                fill_run();
            else if (kind < 85)
                drain_run();
            else
                noise_run();
            if ($urandom_range(0, 9) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (NUM_SLOTS + 16) @(posedge clk);
        $display("Sent %0d commands and checked %0d result beats, with %0d drops on a full table",
                 sent, checked, full_drops);
        $display("and %0d ticks on an empty table.", empty_ticks);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

// ===== priority_unit_work_scheduler.f =====
design/puws_pkg.sv
design/puws_cell.sv
design/priority_unit_work_scheduler.sv
design/puws_checker.sv
sim/sched_checker.sv
sim/tb_top.sv
